### rtl/lrs_pkg.sv
// Shared types and constants for the Life row-step block.
`default_nettype none

package lrs_pkg;

  // Fixed widths of the stream payloads and the width register
  localparam int DATA_W = 64;
  localparam int CFG_W  = 7;

  // Reset value of the grid width register (all 64 columns in use)
  localparam logic [CFG_W-1:0] GRID_WIDTH_RST = 7'd64;

  // Side-band flags for one result row
  typedef struct packed {
    logic grid_end;     // bottom row of the new generation
    logic last_of_run;  // last result caused by one input item
  } lrs_job_t;

endpackage

`default_nettype wire

### rtl/lrs_row_window.sv
// Row history and staged three-row window feeding the next-generation logic.
`default_nettype none

module lrs_row_window #(
  parameter int MAX_CELLS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [MAX_CELLS-1:0] in_row,
  input  wire logic                 in_last,
  input  wire logic                 out_free,
  output logic                      job_valid,
  output lrs_pkg::lrs_job_t         job,
  output logic [MAX_CELLS-1:0]      job_up,
  output logic [MAX_CELLS-1:0]      job_mid,
  output logic [MAX_CELLS-1:0]      job_dn
);
  import lrs_pkg::*;

  // The last two rows of the grid seen so far
  logic [MAX_CELLS-1:0] row_above;
  logic [MAX_CELLS-1:0] row_middle;
  logic                 rows_held;

  // Staged item: window snapshot plus its flags
  logic                 stage_valid;
  logic [MAX_CELLS-1:0] stage_up;
  logic [MAX_CELLS-1:0] stage_mid;
  logic [MAX_CELLS-1:0] stage_dn;
  logic                 stage_held;
  logic                 stage_last;
  logic                 phase;

  logic accept;
  logic has_result;
  logic second_job;
  logic final_job;
  logic advance;
  logic pop;

  assign accept     = in_valid && in_ready;
  assign has_result = stage_held || stage_last;
  // Second kind of job: bottom row (its own next generation with nothing below)
  assign second_job = phase || (!stage_held && stage_last);
  assign final_job  = !(stage_held && stage_last) || phase;
  assign advance    = stage_valid && has_result && out_free;
  assign pop        = stage_valid && (!has_result || (out_free && final_job));
  assign in_ready   = !stage_valid || pop;

  assign job_valid       = stage_valid && has_result;
  assign job.grid_end    = second_job;
  assign job.last_of_run = second_job || !stage_last;
  assign job_up          = second_job ? stage_mid : stage_up;
  assign job_mid         = second_job ? stage_dn  : stage_mid;
  assign job_dn          = second_job ? '0        : stage_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_above   <= '0;
      row_middle  <= '0;
      rows_held   <= 1'b0;
      stage_valid <= 1'b0;
      phase       <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          row_above  <= '0;
          row_middle <= '0;
          rows_held  <= 1'b0;
        end else begin
          row_above  <= row_middle;
          row_middle <= in_row;
          rows_held  <= 1'b1;
        end
        stage_valid <= 1'b1;
      end else if (pop) begin
        stage_valid <= 1'b0;
      end
      if (pop) begin
        phase <= 1'b0;
      end else if (advance) begin
        phase <= 1'b1;
      end
    end
  end

  // Window payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_up   <= row_above;
      stage_mid  <= row_middle;
      stage_dn   <= in_row;
      stage_held <= rows_held;
      stage_last <= in_last;
    end
  end

endmodule

`default_nettype wire

### rtl/lrs_next_gen.sv
// B3/S23 next-generation logic for one row from its three-row window.
`default_nettype none

module lrs_next_gen #(
  parameter int MAX_CELLS = 64
) (
  input  wire logic [MAX_CELLS-1:0] row_up,
  input  wire logic [MAX_CELLS-1:0] row_mid,
  input  wire logic [MAX_CELLS-1:0] row_dn,
  input  wire logic [MAX_CELLS-1:0] mask,
  output logic      [MAX_CELLS-1:0] row_next
);
  import lrs_pkg::*;

  // Rows padded with a dead cell at each edge
  logic [MAX_CELLS+1:0] up_p;
  logic [MAX_CELLS+1:0] mid_p;
  logic [MAX_CELLS+1:0] dn_p;

  assign up_p  = {1'b0, row_up  & mask, 1'b0};
  assign mid_p = {1'b0, row_mid & mask, 1'b0};
  assign dn_p  = {1'b0, row_dn  & mask, 1'b0};

  always_comb begin
    logic [3:0] n;
    row_next = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      n = 4'(up_p[i]) + 4'(up_p[i+1]) + 4'(up_p[i+2])
        + 4'(mid_p[i]) + 4'(mid_p[i+2])
        + 4'(dn_p[i]) + 4'(dn_p[i+1]) + 4'(dn_p[i+2]);
      row_next[i] = mask[i] && ((n == 4'd3) || ((n == 4'd2) && mid_p[i+1]));
    end
  end

endmodule

`default_nettype wire

### rtl/life_automaton_row_step.sv
// Top level: row-streaming Life (B3/S23) generation step on a bounded grid.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/tready  | tdata = row_cells, tlast = last_row
//  m_*     | out | m_tvalid/tready  | tdata = next_cells, tlast = grid_end,
//          |     |                  | tuser = last_of_run
//  cfg_*   | in  | cfg_wr_en        | cfg_wr_data = grid_width
//
// One row item per cycle is taken unless stalled; a row's result leaves after
// the row below it is accepted (window register, then output register). The
// bottom row of a grid of two or more rows yields two results and holds the
// input while the second result moves through the shared rule logic. Reset
// clears the row history, the window and the output valid; grid_width returns
// to 64. A stall on m_tready backs up through the window register.
`default_nettype none

module life_automaton_row_step #(
  parameter int MAX_CELLS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // stream in: tdata[63:0] = row_cells
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [lrs_pkg::DATA_W-1:0] s_tdata,
  input  wire logic                       s_tlast,
  // stream out: tdata[63:0] = next_cells; tuser[0] = last_of_run
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [lrs_pkg::DATA_W-1:0] m_tdata,
  output logic                            m_tlast,
  output logic                            m_tuser,
  // width register
  input  wire logic                       cfg_wr_en,
  input  wire logic [lrs_pkg::CFG_W-1:0]  cfg_wr_data
);
  import lrs_pkg::*;

  logic [CFG_W-1:0]     grid_width;
  logic [MAX_CELLS-1:0] mask;
  logic                 out_free;
  logic                 job_valid;
  lrs_job_t             job;
  logic [MAX_CELLS-1:0] job_up;
  logic [MAX_CELLS-1:0] job_mid;
  logic [MAX_CELLS-1:0] job_dn;
  logic [MAX_CELLS-1:0] row_next;
  logic                 out_load;

  // Width register; to be written only while the block is idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_WIDTH_RST;
    end else if (cfg_wr_en) begin
      grid_width <= cfg_wr_data;
    end
  end

  // Column mask: columns at or beyond grid_width are dead. Columns beyond
  // MAX_CELLS do not exist here, which saturates the width.
  always_comb begin
    for (int i = 0; i < MAX_CELLS; i++) begin
      mask[i] = CFG_W'(i) < grid_width;
    end
  end

  // Output register is free when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign out_load = job_valid && out_free;

  // Drop dead columns on entry so held rows keep the width they arrived with
  lrs_row_window #(
    .MAX_CELLS (MAX_CELLS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_row    (s_tdata[MAX_CELLS-1:0] & mask),
    .in_last   (s_tlast),
    .out_free  (out_free),
    .job_valid (job_valid),
    .job       (job),
    .job_up    (job_up),
    .job_mid   (job_mid),
    .job_dn    (job_dn)
  );

  lrs_next_gen #(
    .MAX_CELLS (MAX_CELLS)
  ) u_next_gen (
    .row_up   (job_up),
    .row_mid  (job_mid),
    .row_dn   (job_dn),
    .mask     (mask),
    .row_next (row_next)
  );

  // Output register: hold while stalled, load the next result when free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= DATA_W'(row_next);
      m_tlast <= job.grid_end;
      m_tuser <= job.last_of_run;
    end
  end

endmodule

`default_nettype wire

### rtl/lrs_checker.sv
// Port-level checks for the Life row-step block, bound to its top level.
`default_nettype none

module lrs_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [lrs_pkg::DATA_W-1:0] m_tdata,
  input wire logic                       m_tlast,
  input wire logic                       m_tuser
);
  import lrs_pkg::*;

  // Nothing leaves in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // A stalled result holds its row
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // The bottom row of a generation always closes its run
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("grid_end without last_of_run");

  // The first of a pair is followed at once by the bottom row
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser |=> m_tvalid && m_tlast && m_tuser)
    else $error("second result of bottom row missing");

endmodule

bind life_automaton_row_step lrs_checker u_lrs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire
